// File: hw/rtl/flow_grid_cell_classifier_defines.svh
// ---------------------------------------------------------------------------
// flow grid cell classifier assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef FLOW_GRID_CELL_CLASSIFIER_DEFINES_SVH
`define FLOW_GRID_CELL_CLASSIFIER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FGCC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FGCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fgcc_pkg.sv
// ---------------------------------------------------------------------------
// fgcc_pkg
// types, codes and small helpers shared by the grid cell classifier
// ---------------------------------------------------------------------------
`default_nettype none

package fgcc_pkg;

  // internal coordinate width: one bit above the 6-bit port fields
  localparam int POS_W = 7;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_DEFAULT = 3'd0;
  localparam logic [2:0] KIND_FLUID   = 3'd1;
  localparam logic [2:0] KIND_OUTLET  = 3'd2;
  localparam logic [2:0] KIND_INLET   = 3'd3;
  localparam logic [2:0] KIND_NOSLIP  = 3'd4;
  localparam logic [2:0] KIND_FREE    = 3'd5;

  // code thresholds
  localparam logic [7:0] CODE_FLUID     = 8'd0;
  localparam logic [7:0] CODE_OUTLET    = 8'd1;
  localparam logic [7:0] CODE_INLET_MAX = 8'd9;
  localparam logic [7:0] CODE_WALL_MIN  = 8'd10;
  localparam logic [7:0] CODE_NOSLIP_MAX = 8'd19;

  // march directions
  localparam logic [1:0] DIR_PX = 2'd0;
  localparam logic [1:0] DIR_MX = 2'd1;
  localparam logic [1:0] DIR_PY = 2'd2;
  localparam logic [1:0] DIR_MY = 2'd3;

  localparam logic [21:0] DIST_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] r;
  } pos_t;

  typedef struct packed {
    logic [5:0]  cols;
    logic [5:0]  rows;
    logic [15:0] cell_width;
    logic [15:0] cell_height;
  } cfg_t;

  // one step from p in direction d, wrapping below zero
  function automatic pos_t step_pos(pos_t p, logic [1:0] d);
    pos_t q;
    q = p;
    case (d)
      DIR_PX:  q.c = p.c + POS_W'(1);
      DIR_MX:  q.c = p.c - POS_W'(1);
      DIR_PY:  q.r = p.r + POS_W'(1);
      DIR_MY:  q.r = p.r - POS_W'(1);
      default: q = p;
    endcase
    return q;
  endfunction

  // border mask bit to neighbor direction: left, right, top, bottom
  function automatic logic [1:0] mask_dir(logic [1:0] k);
    logic [1:0] d;
    case (k)
      2'd0:    d = DIR_MX;
      2'd1:    d = DIR_PX;
      2'd2:    d = DIR_PY;
      default: d = DIR_MY;
    endcase
    return d;
  endfunction

  // inside the configured interior, ghost ring excluded
  function automatic logic is_interior(pos_t p, logic [5:0] m, logic [5:0] n);
    return (p.c != '0) && (p.c <= {1'b0, m}) && (p.r != '0) && (p.r <= {1'b0, n});
  endfunction

  function automatic logic [2:0] kind_of(logic [7:0] code, logic fluid);
    logic [2:0] k;
    if (fluid) begin
      k = KIND_FLUID;
    end else if (code == CODE_FLUID) begin
      k = KIND_DEFAULT;
    end else if (code == CODE_OUTLET) begin
      k = KIND_OUTLET;
    end else if (code <= CODE_INLET_MAX) begin
      k = KIND_INLET;
    end else if (code <= CODE_NOSLIP_MAX) begin
      k = KIND_NOSLIP;
    end else begin
      k = KIND_FREE;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fgcc_in_if.sv
// ---------------------------------------------------------------------------
// fgcc_in_if
// command channel: cell loads and cell queries
// ---------------------------------------------------------------------------
`default_nettype none

interface fgcc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [5:0] col;
  logic [5:0] row;
  logic [7:0] code_value;

  modport source (output valid, opcode, col, row, code_value, input ready);
  modport sink   (input valid, opcode, col, row, code_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fgcc_out_if.sv
// ---------------------------------------------------------------------------
// fgcc_out_if
// result channel: one beat per query
// ---------------------------------------------------------------------------
`default_nettype none

interface fgcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cell_kind;
  logic [7:0]  cell_code;
  logic [3:0]  border_mask;
  logic        wall_found;
  logic [21:0] wall_distance;
  logic [1:0]  wall_direction;
  logic        out_of_range;

  modport source (output valid, cell_kind, cell_code, border_mask, wall_found,
                  wall_distance, wall_direction, out_of_range, input ready);
  modport sink   (input valid, cell_kind, cell_code, border_mask, wall_found,
                  wall_distance, wall_direction, out_of_range, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fgcc_cfg.sv
// ---------------------------------------------------------------------------
// fgcc_cfg
// apb register file: grid size and cell spacing, size clamped to storage
// ---------------------------------------------------------------------------
`default_nettype none

module fgcc_cfg import fgcc_pkg::*; #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  localparam logic [1:0] REG_COLS   = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int MAX_COLS = GRID_COLS - 2;
  localparam int MAX_ROWS = GRID_ROWS - 2;

  logic [5:0]  interior_cols;
  logic [5:0]  interior_rows;
  logic [15:0] cell_width;
  logic [15:0] cell_height;
  logic        wr;

  assign wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interior_cols <= 6'd62;
      interior_rows <= 6'd62;
      cell_width    <= 16'd256;
      cell_height   <= 16'd256;
    end else if (wr) begin
      case (paddr[3:2])
        REG_COLS:   interior_cols <= pwdata[5:0];
        REG_ROWS:   interior_rows <= pwdata[5:0];
        REG_WIDTH:  cell_width    <= pwdata[15:0];
        REG_HEIGHT: cell_height   <= pwdata[15:0];
        default:    interior_cols <= interior_cols;
      endcase
    end
  end

  // read back raw values
  always_comb begin
    case (paddr[3:2])
      REG_COLS:   prdata = {26'd0, interior_cols};
      REG_ROWS:   prdata = {26'd0, interior_rows};
      REG_WIDTH:  prdata = {16'd0, cell_width};
      REG_HEIGHT: prdata = {16'd0, cell_height};
      default:    prdata = '0;
    endcase
  end

  // clamp interior size to what the storage holds, and raise zero to one
  always_comb begin
    if (interior_cols == '0) begin
      cfg.cols = 6'd1;
    end else if (int'(interior_cols) > MAX_COLS) begin
      cfg.cols = 6'(MAX_COLS);
    end else begin
      cfg.cols = interior_cols;
    end
    if (interior_rows == '0) begin
      cfg.rows = 6'd1;
    end else if (int'(interior_rows) > MAX_ROWS) begin
      cfg.rows = 6'(MAX_ROWS);
    end else begin
      cfg.rows = interior_rows;
    end
    cfg.cell_width  = cell_width;
    cfg.cell_height = cell_height;
  end

endmodule

`default_nettype wire

// File: hw/rtl/flow_grid_cell_classifier.sv
// ---------------------------------------------------------------------------
// flow_grid_cell_classifier
// cell code store with query-time classification and wall distance march
// ---------------------------------------------------------------------------
// Cell codes live in a store of GRID_COLS*GRID_ROWS bytes with one write
// port and one registered read port, addressed row*GRID_COLS+col, with no
// reset: every cell a query touches must have been loaded first. A load is
// written from the idle state. A query outside the configured grid goes
// straight to the result; one on a non-fluid cell reads the center plus the
// four neighbors. A fluid cell is marched in +x, -x, +y, -y with one store
// read per cycle, and each direction's march ends in a distance and a
// best-wall step. The +x and -x marches of one cell span at most the
// clamped column count plus one steps together, and likewise in y; the one
// read port of the store serialises the march. Each distance goes through
// one shared 7x16 multiplier. The query port is ready only while the
// sequencer is idle; a finished result waits in the output register and
// the next command is taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

`include "flow_grid_cell_classifier_defines.svh"

module flow_grid_cell_classifier import fgcc_pkg::*; #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  fgcc_in_if.sink     query,
  fgcc_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CENTER = 3'd1;
  localparam logic [2:0] S_NBR    = 3'd2;
  localparam logic [2:0] S_MARCH  = 3'd3;
  localparam logic [2:0] S_DIST   = 3'd4;
  localparam logic [2:0] S_BEST   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  cfg_t cfg;

  logic [2:0]  state, state_next;
  pos_t        qpos, qpos_next;
  pos_t        pos, pos_next;
  logic [1:0]  dk, dk_next;
  logic [6:0]  steps, steps_next;
  logic        wall, wall_next;
  logic [22:0] prod;
  logic [21:0] sat_dist;

  logic [2:0]  kind, kind_next;
  logic [7:0]  code, code_next;
  logic [3:0]  mask, mask_next;
  logic        found, found_next;
  logic [21:0] best, best_next;
  logic [1:0]  wdir, wdir_next;
  logic        oor, oor_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          fluid;
  logic          out_load;

  fgcc_cfg #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready      = 1'b1;
  assign query.ready = (state == S_IDLE);
  assign out_load    = (state == S_DONE) && (!result.valid || result.ready);

  // store addressing
  assign wr_addr = AW'(int'(query.row) * GRID_COLS + int'(query.col));
  assign rd_addr = AW'(int'(pos_next.r) * GRID_COLS + int'(pos_next.c));

  // saturated distance from the multiplier register
  assign sat_dist = (prod > {1'b0, DIST_MAX}) ? DIST_MAX : prod[21:0];
  assign fluid    = is_interior(qpos, cfg.cols, cfg.rows) && (rdata == CODE_FLUID);

  // cell code store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= query.code_value;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_next = state;
    qpos_next  = qpos;
    pos_next   = pos;
    dk_next    = dk;
    steps_next = steps;
    wall_next  = wall;
    kind_next  = kind;
    code_next  = code;
    mask_next  = mask;
    found_next = found;
    best_next  = best;
    wdir_next  = wdir;
    oor_next   = oor;
    we         = 1'b0;
    case (state)
      S_IDLE: begin
        pos_next  = '{c: {1'b0, query.col}, r: {1'b0, query.row}};
        qpos_next = pos_next;
        if (query.valid) begin
          if (query.opcode == OP_LOAD) begin
            we = (int'(query.col) < GRID_COLS) && (int'(query.row) < GRID_ROWS);
          end else begin
            oor_next   = ({1'b0, query.col} > ({1'b0, cfg.cols} + 7'd1)) ||
                         ({1'b0, query.row} > ({1'b0, cfg.rows} + 7'd1));
            kind_next  = KIND_DEFAULT;
            code_next  = '0;
            mask_next  = '0;
            found_next = 1'b0;
            wdir_next  = DIR_PX;
            dk_next    = '0;
            if (oor_next) begin
              best_next  = '0;
              state_next = S_DONE;
            end else begin
              best_next  = DIST_MAX;
              state_next = S_CENTER;
            end
          end
        end
      end
      S_CENTER: begin
        code_next = rdata;
        kind_next = kind_of(rdata, fluid);
        if (fluid) begin
          dk_next    = DIR_PX;
          pos_next   = step_pos(qpos, DIR_PX);
          steps_next = 7'd1;
          state_next = S_MARCH;
        end else begin
          dk_next    = 2'd0;
          pos_next   = step_pos(qpos, mask_dir(2'd0));
          state_next = S_NBR;
        end
      end
      S_NBR: begin
        mask_next[dk] = is_interior(pos, cfg.cols, cfg.rows) && (rdata == CODE_FLUID);
        if (dk == 2'd3) begin
          state_next = S_DONE;
        end else begin
          dk_next  = dk + 2'd1;
          pos_next = step_pos(qpos, mask_dir(dk + 2'd1));
        end
      end
      S_MARCH: begin
        if (is_interior(pos, cfg.cols, cfg.rows) && (rdata == CODE_FLUID)) begin
          pos_next   = step_pos(pos, dk);
          steps_next = steps + 7'd1;
        end else begin
          wall_next  = (rdata >= CODE_WALL_MIN);
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        state_next = S_BEST;
      end
      S_BEST: begin
        if (wall && (!found || sat_dist < best)) begin
          best_next = sat_dist;
          wdir_next = dk;
        end
        if (wall) begin
          found_next = 1'b1;
        end
        if (dk == DIR_MY) begin
          state_next = S_DONE;
        end else begin
          dk_next    = dk + 2'd1;
          pos_next   = step_pos(qpos, dk + 2'd1);
          steps_next = 7'd1;
          state_next = S_MARCH;
        end
      end
      S_DONE: begin
        if (!result.valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    qpos  <= qpos_next;
    pos   <= pos_next;
    dk    <= dk_next;
    steps <= steps_next;
    wall  <= wall_next;
    kind  <= kind_next;
    code  <= code_next;
    mask  <= mask_next;
    found <= found_next;
    best  <= best_next;
    wdir  <= wdir_next;
    oor   <= oor_next;
  end

  // shared distance multiplier: steps times spacing of the current axis
  always_ff @(posedge clk) begin
    if (state == S_DIST) begin
      prod <= 23'(steps) *
              23'((dk == DIR_PX || dk == DIR_MX) ? cfg.cell_width : cfg.cell_height);
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.cell_kind      <= kind;
      result.cell_code      <= code;
      result.border_mask    <= mask;
      result.wall_found     <= found;
      result.wall_distance  <= best;
      result.wall_direction <= wdir;
      result.out_of_range   <= oor;
    end
  end

  // checks
  `FGCC_ASSERT_IMPLY(a_nofound_max, result.valid && !result.wall_found && !result.out_of_range, result.wall_distance == DIST_MAX, "no wall but distance not saturated")
  `FGCC_ASSERT_IMPLY(a_found_fluid, result.valid && result.wall_found, result.cell_kind == KIND_FLUID && result.border_mask == 4'd0, "wall found on a non-fluid cell")
  `FGCC_ASSERT_IMPLY(a_march_bound, state == S_MARCH, int'(pos.c) < GRID_COLS && int'(pos.r) < GRID_ROWS && steps != 7'd0, "march left the store")
  `FGCC_ASSERT_NEXT(a_load_idle, query.valid && query.ready && query.opcode == OP_LOAD, state == S_IDLE, "load left the idle state")

endmodule

`default_nettype wire
